// ----- hdl/tgpd_pkg.sv -----
package tgpd_pkg;

  // joint slots: four legs times three joints
  localparam int unsigned NumSlots = 12;
  localparam int unsigned SlotW    = 4;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    JOINT_ABD  = 2'd0,
    JOINT_HIP  = 2'd1,
    JOINT_KNEE = 2'd2
  } joint_e;

  typedef enum logic [2:0] {
    CFG_GAIT_MODE    = 3'd0,
    CFG_KP_ABD       = 3'd1,
    CFG_KP_HIP       = 3'd2,
    CFG_KP_KNEE      = 3'd3,
    CFG_KD_ABD       = 3'd4,
    CFG_KD_HIP       = 3'd5,
    CFG_KD_KNEE      = 3'd6,
    CFG_TORQUE_LIMIT = 3'd7
  } cfg_idx_e;

  // gait and velocity constants
  localparam logic [15:0]        PHASE_STEP     = 16'd524;
  localparam logic [7:0]         VEL_SCALE      = 8'd250;
  localparam logic signed [11:0] HIP_AMP        = 12'sd614;
  localparam logic [10:0]        HIP_SPAN       = 11'd1229;
  localparam logic [26:0]        HIP_ROUND      = 27'd16384;
  localparam logic signed [23:0] HIP_STANCE_VEL = -24'sd2458;
  localparam logic signed [23:0] VEL_MAX        = 24'sh7FFFFF;
  localparam logic signed [23:0] VEL_MIN        = -24'sh800000;
  localparam logic signed [42:0] TORQUE_ROUND   = 43'sd2048;

  // register reset values
  localparam logic        GAIT_MODE_RST    = 1'b0;
  localparam logic [15:0] KP_RST           = 16'd768;
  localparam logic [15:0] KD_ABD_RST       = 16'd256;
  localparam logic [15:0] KD_LEG_RST       = 16'd51;
  localparam logic [14:0] TORQUE_LIMIT_RST = 15'd3840;

  typedef logic [9:0] lift_t;

  // quarter wave of the knee lift, 910 * sin(pi*i/32)
  localparam lift_t LIFT_TABLE [17] = '{
    10'd0,   10'd89,  10'd178, 10'd264, 10'd348, 10'd429, 10'd506, 10'd577, 10'd643,
    10'd703, 10'd757, 10'd803, 10'd841, 10'd871, 10'd893, 10'd906, 10'd910
  };

  // half wave lookup, mirrored around the peak
  function automatic lift_t lift_at(input logic [5:0] i);
    logic [4:0] k;
    k = (i <= 6'd16) ? i[4:0] : 5'(6'd32 - i);
    return LIFT_TABLE[k];
  endfunction

endpackage

// ----- hdl/tgpd_if.sv -----
// joint sample / gait command channel
interface tgpd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [1:0]         leg;
  logic [1:0]         joint;
  logic signed [15:0] angle;
  logic               angle_valid;

  modport source (output valid, operation, leg, joint, angle, angle_valid, input ready);
  modport sink   (input valid, operation, leg, joint, angle, angle_valid, output ready);
endinterface

// torque result channel
interface tgpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] torque;
  logic [1:0]         torque_leg;
  logic [1:0]         torque_joint;
  logic               in_stance;

  modport source (output valid, torque, torque_leg, torque_joint, in_stance, input ready);
  modport sink   (input valid, torque, torque_leg, torque_joint, in_stance, output ready);
endinterface

// ----- hdl/tgpd_target.sv -----
module tgpd_target import tgpd_pkg::*; (
  input  logic               trot_i,
  input  logic               stance_i,
  input  logic [1:0]         joint_i,
  input  logic [14:0]        s_i,
  output logic signed [15:0] q_des_o,
  output logic signed [23:0] qd_des_o
);

  logic [26:0]        hip_prod;
  logic [11:0]        hip_sweep;
  logic signed [11:0] hip_tgt;
  logic [5:0]         idx;
  lift_t              lift_a;
  lift_t              lift_b;
  logic signed [10:0] lift_diff;
  logic signed [20:0] lift_prod;
  logic signed [10:0] lift_step;
  logic signed [11:0] lift_val;

  // linear hip sweep with rounding
  assign hip_prod  = 27'(s_i) * 27'(HIP_SPAN) + HIP_ROUND;
  assign hip_sweep = hip_prod[26:15];
  assign hip_tgt   = HIP_AMP - $signed(hip_sweep);

  // knee lift, table interpolation truncated toward zero
  assign idx       = {1'b0, s_i[14:10]};
  assign lift_a    = lift_at(idx);
  assign lift_b    = lift_at(idx + 6'd1);
  assign lift_diff = $signed({1'b0, lift_b}) - $signed({1'b0, lift_a});
  assign lift_prod = lift_diff * $signed({1'b0, s_i[9:0]});
  assign lift_step = lift_prod[20] ? 11'((lift_prod + 21'sd1023) >>> 10)
                                   : 11'(lift_prod >>> 10);
  assign lift_val  = $signed({2'b00, lift_a}) + 12'(lift_step);

  // target selection per joint and gait phase
  always_comb begin
    q_des_o  = '0;
    qd_des_o = '0;
    if (trot_i) begin
      if (joint_i == JOINT_HIP) begin
        q_des_o  = 16'(hip_tgt);
        qd_des_o = stance_i ? HIP_STANCE_VEL : '0;
      end else if (joint_i == JOINT_KNEE && !stance_i) begin
        q_des_o  = -16'(lift_val);
      end
    end
  end

endmodule

// ----- hdl/trot_gait_joint_pd_controller_top.sv -----
// channel   dir  payload                                         request
// in_i      in   operation, leg, joint, angle, angle_valid       sample, tick or phase clear
// out_o     out  torque, torque_leg, torque_joint, in_stance     one per joint sample
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                 register write
//
// five register stages: input, state update, targets, products, result
// one request per cycle unless the output stalls
// ticks and phase clears update the phase; they and ignored requests leave no result
// reset clears phase, joint stores and stage valid flags, and config to its defaults
// each stage holds while the next is full, bubbles close up, so input stays
// ready while a finished torque waits at the output, until the stages fill
module trot_gait_joint_pd_controller_top import tgpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tgpd_in_if.sink     in_i,
  tgpd_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // configuration
  logic        gait_mode_q;
  logic [15:0] kp_abd_q, kp_hip_q, kp_knee_q;
  logic [15:0] kd_abd_q, kd_hip_q, kd_knee_q;
  logic [14:0] torque_limit_q;

  // state
  logic [15:0]        phase_q;
  logic signed [15:0] angle_q [NumSlots];
  logic signed [23:0] vel_q   [NumSlots];

  // stage 1: input register
  logic               vld1_q;
  logic [1:0]         op1_q, leg1_q, joint1_q;
  logic signed [15:0] angle1_q;
  logic               avld1_q;

  // stage 2
  logic               vld2_q;
  logic [1:0]         leg2_q, joint2_q;
  logic signed [15:0] q2_q;
  logic signed [23:0] qd2_q;
  logic [14:0]        s2_q;
  logic               stance2_q, trot2_q;

  // stage 3
  logic               vld3_q;
  logic [1:0]         leg3_q, joint3_q;
  logic signed [15:0] q3_q, q_des3_q;
  logic signed [23:0] qd3_q, qd_des3_q;
  logic               stance3_q;

  // stage 4
  logic               vld4_q;
  logic [1:0]         leg4_q, joint4_q;
  logic signed [33:0] pkp4_q;
  logic signed [41:0] pkd4_q;
  logic               stance4_q;

  // result register
  logic               out_vld_q;
  logic signed [15:0] torque_q;
  logic [1:0]         leg5_q, joint5_q;
  logic               stance5_q;

  logic rdy2, rdy3, rdy4, rdy5, mv1;

  // stage advance: a stage takes new data when empty or emptying
  assign rdy5 = !out_vld_q || out_o.ready;
  assign rdy4 = !vld4_q || rdy5;
  assign rdy3 = !vld3_q || rdy4;
  assign rdy2 = !vld2_q || rdy3;
  assign in_i.ready = !vld1_q || rdy2;
  assign mv1 = vld1_q && rdy2;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gait_mode_q    <= GAIT_MODE_RST;
      kp_abd_q       <= KP_RST;
      kp_hip_q       <= KP_RST;
      kp_knee_q      <= KP_RST;
      kd_abd_q       <= KD_ABD_RST;
      kd_hip_q       <= KD_LEG_RST;
      kd_knee_q      <= KD_LEG_RST;
      torque_limit_q <= TORQUE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIT_MODE:    gait_mode_q    <= cfg_data_i[0];
        CFG_KP_ABD:       kp_abd_q       <= cfg_data_i;
        CFG_KP_HIP:       kp_hip_q       <= cfg_data_i;
        CFG_KP_KNEE:      kp_knee_q      <= cfg_data_i;
        CFG_KD_ABD:       kd_abd_q       <= cfg_data_i;
        CFG_KD_HIP:       kd_hip_q       <= cfg_data_i;
        CFG_KD_KNEE:      kd_knee_q      <= cfg_data_i;
        CFG_TORQUE_LIMIT: torque_limit_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // stage 1: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (in_i.ready) begin
      vld1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op1_q    <= in_i.operation;
      leg1_q   <= in_i.leg;
      joint1_q <= in_i.joint;
      angle1_q <= in_i.angle;
      avld1_q  <= in_i.angle_valid;
    end
  end

  // stage 2: joint store read, velocity estimate, leg phase
  logic               is_sample;
  logic [SlotW-1:0]   slot;
  logic signed [15:0] cur_angle;
  logic signed [23:0] cur_vel;
  logic signed [16:0] ang_diff;
  logic signed [24:0] vel_raw;
  logic signed [23:0] vel_sat;
  logic [15:0]        limb_phase;
  logic               stance;

  assign is_sample = (op1_q == OP_SAMPLE) &&
                     (joint1_q inside {JOINT_ABD, JOINT_HIP, JOINT_KNEE});
  assign slot      = SlotW'({leg1_q, 1'b0}) + SlotW'(leg1_q) + SlotW'(joint1_q);
  assign cur_angle = angle_q[slot];
  assign cur_vel   = vel_q[slot];
  assign ang_diff  = 17'(angle1_q) - 17'(cur_angle);
  assign vel_raw   = 25'(ang_diff) * $signed(25'(VEL_SCALE));

  // saturate to the 24-bit velocity range
  always_comb begin
    if (vel_raw[24] != vel_raw[23]) begin
      vel_sat = vel_raw[24] ? VEL_MIN : VEL_MAX;
    end else begin
      vel_sat = vel_raw[23:0];
    end
  end

  // legs 1 and 2 run half a cycle apart from the other diagonal
  assign limb_phase = phase_q + ((leg1_q == 2'd1 || leg1_q == 2'd2) ? 16'h8000 : 16'h0000);
  assign stance     = gait_mode_q && !limb_phase[15];

  // gait phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (mv1 && op1_q == OP_TICK) begin
      phase_q <= phase_q + PHASE_STEP;
    end else if (mv1 && op1_q == OP_CLEAR) begin
      phase_q <= '0;
    end
  end

  // joint angle and velocity stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        angle_q[i] <= '0;
        vel_q[i]   <= '0;
      end
    end else if (mv1 && is_sample && avld1_q) begin
      angle_q[slot] <= angle1_q;
      vel_q[slot]   <= vel_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (rdy2) begin
      vld2_q <= vld1_q && is_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      leg2_q    <= leg1_q;
      joint2_q  <= joint1_q;
      q2_q      <= avld1_q ? angle1_q : cur_angle;
      qd2_q     <= avld1_q ? vel_sat : cur_vel;
      s2_q      <= limb_phase[14:0];
      stance2_q <= stance;
      trot2_q   <= gait_mode_q;
    end
  end

  // stage 3: desired angle and velocity
  logic signed [15:0] q_des;
  logic signed [23:0] qd_des;

  tgpd_target u_target (
    .trot_i   (trot2_q),
    .stance_i (stance2_q),
    .joint_i  (joint2_q),
    .s_i      (s2_q),
    .q_des_o  (q_des),
    .qd_des_o (qd_des)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (rdy3) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld2_q && rdy3) begin
      leg3_q    <= leg2_q;
      joint3_q  <= joint2_q;
      q3_q      <= q2_q;
      qd3_q     <= qd2_q;
      q_des3_q  <= q_des;
      qd_des3_q <= qd_des;
      stance3_q <= stance2_q;
    end
  end

  // stage 4: errors times per-joint gains
  logic [15:0]        kp_sel, kd_sel;
  logic signed [16:0] err_q;
  logic signed [24:0] err_qd;

  always_comb begin
    case (joint3_q)
      JOINT_ABD: begin
        kp_sel = kp_abd_q;
        kd_sel = kd_abd_q;
      end
      JOINT_HIP: begin
        kp_sel = kp_hip_q;
        kd_sel = kd_hip_q;
      end
      default: begin
        kp_sel = kp_knee_q;
        kd_sel = kd_knee_q;
      end
    endcase
  end

  assign err_q  = 17'(q_des3_q) - 17'(q3_q);
  assign err_qd = 25'(qd_des3_q) - 25'(qd3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else if (rdy4) begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld3_q && rdy4) begin
      leg4_q    <= leg3_q;
      joint4_q  <= joint3_q;
      pkp4_q    <= 34'($signed({1'b0, kp_sel})) * 34'(err_q);
      pkd4_q    <= 42'($signed({1'b0, kd_sel})) * 42'(err_qd);
      stance4_q <= stance3_q;
    end
  end

  // stage 5: sum, round to Q8.8, clamp
  logic signed [42:0] torque_sum;
  logic signed [30:0] torque_full;
  logic signed [30:0] lim_pos;
  logic signed [30:0] lim_neg;
  logic signed [30:0] torque_clamp;

  assign torque_sum  = 43'(pkp4_q) + 43'(pkd4_q) + TORQUE_ROUND;
  assign torque_full = torque_sum[42:12];
  assign lim_pos     = $signed(31'(torque_limit_q));
  assign lim_neg     = -lim_pos;

  always_comb begin
    if (torque_full > lim_pos) begin
      torque_clamp = lim_pos;
    end else if (torque_full < lim_neg) begin
      torque_clamp = lim_neg;
    end else begin
      torque_clamp = torque_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy5) begin
      out_vld_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld4_q && rdy5) begin
      torque_q  <= torque_clamp[15:0];
      leg5_q    <= leg4_q;
      joint5_q  <= joint4_q;
      stance5_q <= stance4_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.torque       = torque_q;
  assign out_o.torque_leg   = leg5_q;
  assign out_o.torque_joint = joint5_q;
  assign out_o.in_stance    = stance5_q;

  // checks
  a_phase_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv1 && op1_q == OP_TICK) |=> (phase_q == $past(phase_q) + PHASE_STEP))
    else $error("phase did not advance on tick");

  a_phase_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv1 && op1_q == OP_CLEAR) |=> (phase_q == '0))
    else $error("phase not cleared");

  a_no_result_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv1 && !is_sample) |=> !vld2_q)
    else $error("non-sample request produced a result");

  a_stage4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld4_q && !rdy4) |=> vld4_q)
    else $error("stalled product stage lost its request");

endmodule
